// ===== rtl/hstc_pkg.sv =====
// Shared types, constants and the per-bit Exp-Golomb step for the slice type classifier.
// No dependencies.
package hstc_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam logic [4:0] NAL_MASK  = 5'h1f;
    localparam logic [4:0] NAL_SPS   = 5'd7;
    localparam logic [3:0] IDX_MAX   = 4'd15;
    localparam logic [8:0] CODE_SAT  = 9'd256;
    localparam logic [7:0] SLICE_MAX = 8'd255;

    localparam logic [1:0] CLS_I = 2'd0;
    localparam logic [1:0] CLS_P = 2'd1;
    localparam logic [1:0] CLS_B = 2'd2;

    typedef enum logic [4:0] {
        PH_PFX1 = 5'b00001,
        PH_SFX1 = 5'b00010,
        PH_PFX2 = 5'b00100,
        PH_SFX2 = 5'b01000,
        PH_DONE = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [5:0]  zero_run;
        logic [5:0]  suffix_left;
        logic [8:0]  code_value;
    } parse_st_t;

    typedef struct packed {
        logic [4:0] nal_type;
        logic [7:0] slice_code;
        logic       short_packet;
    } raw_t;

    localparam parse_st_t PARSE_CLEAR = '{phase: PH_PFX1, zero_run: 6'd0,
                                          suffix_left: 6'd0, code_value: 9'd0};

    function automatic parse_st_t take_bit(parse_st_t s, logic b, logic at_end,
                                           logic [5:0] max_prefix);
        parse_st_t  n;
        logic       proper;
        logic [5:0] sl;
        n      = s;
        proper = ~(~b & at_end);
        sl     = s.suffix_left - 6'd1;
        unique case (s.phase)
            PH_PFX1, PH_PFX2:
            begin
                if (!b && !at_end && (s.zero_run < max_prefix))
                begin
                    n.zero_run = s.zero_run + 6'd1;
                end
                else
                begin
                    n.suffix_left = s.zero_run;
                    n.code_value  = (s.zero_run < 6'd8)
                                    ? ((9'd1 << s.zero_run[2:0]) - 9'd1) : CODE_SAT;
                    n.zero_run    = 6'd0;
                    if (proper && (s.zero_run == 6'd0))
                    begin
                        n.phase = (s.phase == PH_PFX1) ? PH_PFX2 : PH_DONE;
                    end
                    else
                    begin
                        n.phase = (s.phase == PH_PFX1) ? PH_SFX1 : PH_SFX2;
                    end
                end
            end
            PH_SFX1, PH_SFX2:
            begin
                if (s.suffix_left != 6'd0)
                begin
                    n.suffix_left = sl;
                    if (b && (s.code_value < CODE_SAT) && (sl < 6'd8))
                    begin
                        n.code_value = s.code_value + (9'd1 << sl[2:0]);
                    end
                    if (sl == 6'd0)
                    begin
                        n.phase = (s.phase == PH_SFX1) ? PH_PFX2 : PH_DONE;
                    end
                end
            end
            PH_DONE:
            begin
                n = s;
            end
            default:
            begin
                n = s;
            end
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/hstc_parser.sv =====
// Front end: takes packet bytes, captures the NAL type and decodes both Exp-Golomb codes.
// Depends on hstc_pkg.
module hstc_parser
    import hstc_pkg::*;
#(
    parameter int HEADER_OFFSET = 4,
    parameter int MAX_PREFIX    = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    output logic       raw_push,
    output raw_t       raw_data
);

    logic [3:0] byte_idx_reg, byte_idx_base, byte_idx_next;
    logic [4:0] nal_hold_reg, nal_hold_base, nal_hold_next;
    parse_st_t  st_reg, st_base, st_next;

    always_comb
    begin
        byte_idx_base = first_byte ? 4'd0 : byte_idx_reg;
        nal_hold_base = first_byte ? 5'd0 : nal_hold_reg;
        st_base       = first_byte ? PARSE_CLEAR : st_reg;

        nal_hold_next = nal_hold_base;
        st_next       = st_base;
        if (byte_idx_base == 4'(HEADER_OFFSET))
        begin
            nal_hold_next = data_byte[4:0] & NAL_MASK;
        end
        else if (byte_idx_base > 4'(HEADER_OFFSET))
        begin
            for (int k = 7; k >= 0; k--)
            begin
                st_next = take_bit(st_next, data_byte[k], last_byte && (k == 0),
                                   6'(MAX_PREFIX));
            end
        end
        byte_idx_next = (byte_idx_base < IDX_MAX) ? byte_idx_base + 4'd1 : byte_idx_base;
    end

    always_comb
    begin
        raw_push          = take & last_byte;
        raw_data.nal_type = nal_hold_next;
        if ((st_next.phase == PH_SFX2) || (st_next.phase == PH_DONE))
        begin
            raw_data.slice_code = (st_next.code_value > 9'd255) ? SLICE_MAX
                                                                : st_next.code_value[7:0];
        end
        else
        begin
            raw_data.slice_code = 8'd0;
        end
        raw_data.short_packet = (st_next.phase != PH_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_idx_reg <= 4'd0;
            nal_hold_reg <= 5'd0;
            st_reg       <= PARSE_CLEAR;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                byte_idx_reg <= 4'd0;
                nal_hold_reg <= 5'd0;
                st_reg       <= PARSE_CLEAR;
            end
            else
            begin
                byte_idx_reg <= byte_idx_next;
                nal_hold_reg <= nal_hold_next;
                st_reg       <= st_next;
            end
        end
    end

endmodule

// ===== rtl/hstc_queue.sv =====
// Short queue of parsed packet headers between the parser and the output stage.
// Depends on hstc_pkg.
module hstc_queue
    import hstc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  raw_t wr_data,
    output logic q_full,
    input  logic rd_en,
    output raw_t rd_data,
    output logic q_empty
);

    raw_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_wr, do_rd;

    assign q_full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en & ~q_full;
    assign do_rd   = rd_en & ~q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/hstc_emit.sv =====
// Back end: classifies a queued header into I/P/B, derives drop and flush, holds the result.
// Depends on hstc_pkg.
module hstc_emit
    import hstc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  raw_t       q_data,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic [4:0] nal_type,
    output logic [7:0] slice_code,
    output logic [1:0] frame_class,
    output logic       drop_packet,
    output logic       flush_queue,
    output logic       short_packet
);

    logic       valid_reg;
    logic [4:0] nal_reg;
    logic [7:0] slice_reg;
    logic [1:0] class_reg, class_next;
    logic       drop_reg, flush_reg, short_reg;
    logic       load;

    assign load  = ~q_empty & (~valid_reg | pop);
    assign q_pop = load;

    always_comb
    begin
        priority if ((q_data.slice_code == 8'd2) || (q_data.slice_code == 8'd4) ||
                     (q_data.slice_code == 8'd7) || (q_data.slice_code == 8'd9))
        begin
            class_next = CLS_I;
        end
        else if ((q_data.slice_code == 8'd1) || (q_data.slice_code == 8'd6))
        begin
            class_next = CLS_B;
        end
        else
        begin
            class_next = CLS_P;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            nal_reg   <= q_data.nal_type;
            slice_reg <= q_data.slice_code;
            class_reg <= class_next;
            drop_reg  <= (class_next == CLS_B);
            flush_reg <= (q_data.nal_type == NAL_SPS) && (class_next != CLS_B);
            short_reg <= q_data.short_packet;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign empty        = ~valid_reg;
    assign nal_type     = nal_reg;
    assign slice_code   = slice_reg;
    assign frame_class  = class_reg;
    assign drop_packet  = drop_reg;
    assign flush_queue  = flush_reg;
    assign short_packet = short_reg;

endmodule

// ===== rtl/h264_slice_type_classifier_core.sv =====
// Slice type classifier top: parser front end, header queue, classify/output back end.
// Throughput: one byte per cycle while full is low; full rises only when two headers wait behind a held output.
// A result enters the queue at the edge accepting its last byte, then the output registers once they are free.
// Reset (rst_n, async, active low) clears the parser, empties the queue and the output stage.
// Depends on hstc_pkg, hstc_parser, hstc_queue, hstc_emit.
module h264_slice_type_classifier_core
    import hstc_pkg::*;
#(
    parameter int HEADER_OFFSET = 4,
    parameter int MAX_PREFIX    = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    input  logic       pop,
    output logic       empty,
    output logic [4:0] nal_type,
    output logic [7:0] slice_code,
    output logic [1:0] frame_class,
    output logic       drop_packet,
    output logic       flush_queue,
    output logic       short_packet
);

    logic take;
    logic raw_push;
    raw_t raw_data;
    logic q_full, q_empty, q_pop;
    raw_t q_data;

    assign full = q_full;
    assign take = push & ~q_full;

    hstc_parser #(
        .HEADER_OFFSET (HEADER_OFFSET),
        .MAX_PREFIX    (MAX_PREFIX)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .raw_push   (raw_push),
        .raw_data   (raw_data)
    );

    hstc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (raw_push),
        .wr_data (raw_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_empty (q_empty)
    );

    hstc_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .nal_type     (nal_type),
        .slice_code   (slice_code),
        .frame_class  (frame_class),
        .drop_packet  (drop_packet),
        .flush_queue  (flush_queue),
        .short_packet (short_packet)
    );

endmodule
